// File: src/dpcr_pkg.sv
// ----------------------------------------------------------------------------
// dpcr_pkg: shared types and constants for the disc pair collision resolver
// Item layouts, datapath widths and the side data carried down the pipeline.
// ----------------------------------------------------------------------------
package dpcr_pkg;

  localparam int CW    = 20;            // coordinate width, signed
  localparam int RW    = 14;            // radius width, unsigned
  localparam int RSW   = RW + 1;        // radius sum
  localparam int MW    = CW;            // delta magnitude
  localparam int DVW   = CW + 1;        // coordinate difference, signed
  localparam int SQW   = 2 * RSW;       // squared distances that can touch
  localparam int DXF   = 7;             // extra fraction bits of the distance
  localparam int XW    = SQW + 2 * DXF; // sqrt operand
  localparam int DISTW = XW / 2;        // distance
  localparam int NFB   = 15;            // normal fraction bits
  localparam int NW    = NFB + 2;       // signed normal component
  localparam int NORM_ONE = 1 << NFB;
  localparam int QW    = NW + 1;        // quotient bits computed
  localparam int RMW   = DISTW + QW;    // divider remainder
  localparam int OVW   = RSW + DXF + 1; // overlap, signed
  localparam int PDW   = DVW + NW;
  localparam int DOTW  = PDW + 1;
  localparam int POW   = OVW + NW;
  localparam int PSH   = NFB + DXF + 1; // half overlap times normal
  localparam int PXW   = 18;
  localparam int IMPW  = 25;
  localparam int QVW   = IMPW + NW;
  localparam int DVRW  = 28;

  typedef struct packed {
    logic signed [CW-1:0] first_pos_x;
    logic signed [CW-1:0] first_pos_y;
    logic signed [CW-1:0] first_vel_x;
    logic signed [CW-1:0] first_vel_y;
    logic        [RW-1:0] first_radius;
    logic signed [CW-1:0] second_pos_x;
    logic signed [CW-1:0] second_pos_y;
    logic signed [CW-1:0] second_vel_x;
    logic signed [CW-1:0] second_vel_y;
    logic        [RW-1:0] second_radius;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] new_first_pos_x;
    logic signed [CW-1:0] new_first_pos_y;
    logic signed [CW-1:0] new_first_vel_x;
    logic signed [CW-1:0] new_first_vel_y;
    logic signed [CW-1:0] new_second_pos_x;
    logic signed [CW-1:0] new_second_pos_y;
    logic signed [CW-1:0] new_second_vel_x;
    logic signed [CW-1:0] new_second_vel_y;
    logic                 hit;
  } out_item_t;

  typedef struct packed {
    in_item_t       item;
    logic           hit;
    logic           neg_x;
    logic           neg_y;
    logic [RSW-1:0] mag_x;
    logic [RSW-1:0] mag_y;
    logic [RSW-1:0] rsum;
  } side_t;

endpackage

// File: src/dpcr_front.sv
// ----------------------------------------------------------------------------
// dpcr_front: deltas, squared distance and touch test
// Three stages: delta magnitudes, squares, sum and compare.
// ----------------------------------------------------------------------------
module dpcr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  dpcr_pkg::in_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output dpcr_pkg::side_t           out_side_o,
  output logic [dpcr_pkg::XW-1:0]   out_x_o
);

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  // stage 1
  dpcr_pkg::in_item_t               item1_q;
  logic [dpcr_pkg::MW-1:0]          mx1_q, my1_q, mx1_d, my1_d;
  logic                             nx1_q, ny1_q;
  logic [dpcr_pkg::RSW-1:0]         rs1_q, rs1_d;
  logic signed [dpcr_pkg::DVW-1:0]  dx_w, dy_w;

  // stage 2
  dpcr_pkg::in_item_t               item2_q;
  logic [2*dpcr_pkg::MW-1:0]        sqx2_q, sqy2_q;
  logic [dpcr_pkg::SQW-1:0]         rsq2_q;
  logic [dpcr_pkg::RSW-1:0]         mx2_q, my2_q, rs2_q;
  logic                             nx2_q, ny2_q;

  // stage 3
  dpcr_pkg::side_t                  side3_q, side3_d;
  logic [dpcr_pkg::XW-1:0]          x3_q, x3_d;
  logic [2*dpcr_pkg::MW:0]          d2_w;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_comb begin
    dx_w  = $signed({in_item_i.second_pos_x[dpcr_pkg::CW-1], in_item_i.second_pos_x})
          - $signed({in_item_i.first_pos_x[dpcr_pkg::CW-1], in_item_i.first_pos_x});
    dy_w  = $signed({in_item_i.second_pos_y[dpcr_pkg::CW-1], in_item_i.second_pos_y})
          - $signed({in_item_i.first_pos_y[dpcr_pkg::CW-1], in_item_i.first_pos_y});
    mx1_d = dx_w[dpcr_pkg::DVW-1] ? dpcr_pkg::MW'(-dx_w) : dpcr_pkg::MW'(dx_w);
    my1_d = dy_w[dpcr_pkg::DVW-1] ? dpcr_pkg::MW'(-dy_w) : dpcr_pkg::MW'(dy_w);
    rs1_d = {1'b0, in_item_i.first_radius} + {1'b0, in_item_i.second_radius};
  end

  always_comb begin
    d2_w               = {1'b0, sqx2_q} + {1'b0, sqy2_q};
    side3_d.item       = item2_q;
    side3_d.hit        = (d2_w != '0) && (d2_w < (2*dpcr_pkg::MW+1)'(rsq2_q));
    side3_d.neg_x      = nx2_q;
    side3_d.neg_y      = ny2_q;
    side3_d.mag_x      = mx2_q;
    side3_d.mag_y      = my2_q;
    side3_d.rsum       = rs2_q;
    x3_d               = {d2_w[dpcr_pkg::SQW-1:0], {(2*dpcr_pkg::DXF){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      item1_q <= in_item_i;
      mx1_q   <= mx1_d;
      my1_q   <= my1_d;
      nx1_q   <= dx_w[dpcr_pkg::DVW-1];
      ny1_q   <= dy_w[dpcr_pkg::DVW-1];
      rs1_q   <= rs1_d;
    end
    if (en2) begin
      item2_q <= item1_q;
      sqx2_q  <= mx1_q * mx1_q;
      sqy2_q  <= my1_q * my1_q;
      rsq2_q  <= rs1_q * rs1_q;
      // only the low bits matter once the pair touches
      mx2_q   <= mx1_q[dpcr_pkg::RSW-1:0];
      my2_q   <= my1_q[dpcr_pkg::RSW-1:0];
      nx2_q   <= nx1_q;
      ny2_q   <= ny1_q;
      rs2_q   <= rs1_q;
    end
    if (en3) begin
      side3_q <= side3_d;
      x3_q    <= x3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_side_o  = side3_q;
  assign out_x_o     = x3_q;

endmodule

// File: src/dpcr_sqrt.sv
// ----------------------------------------------------------------------------
// dpcr_sqrt: pipelined integer square root
// Digit by digit root, two result bits per stage.
// ----------------------------------------------------------------------------
module dpcr_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dpcr_pkg::side_t             in_side_i,
  input  logic [dpcr_pkg::XW-1:0]     in_x_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dpcr_pkg::side_t             out_side_o,
  output logic [dpcr_pkg::DISTW-1:0]  out_dist_o
);

  localparam int NS = dpcr_pkg::DISTW / 2;

  logic                      v_q    [NS];
  dpcr_pkg::side_t           side_q [NS];
  logic [dpcr_pkg::XW-1:0]   rem_q  [NS];
  logic [dpcr_pkg::XW-1:0]   root_q [NS];
  logic [dpcr_pkg::XW-1:0]   rem_d  [NS];
  logic [dpcr_pkg::XW-1:0]   root_d [NS];
  logic                      src_v    [NS];
  dpcr_pkg::side_t           src_side [NS];
  logic [dpcr_pkg::XW-1:0]   src_rem  [NS];
  logic [dpcr_pkg::XW-1:0]   src_root [NS];
  logic                      en [NS+1];

  assign en[NS] = out_ready_i;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    if (g == 0) begin : g_src0
      assign src_v[g]    = in_valid_i;
      assign src_side[g] = in_side_i;
      assign src_rem[g]  = in_x_i;
      assign src_root[g] = '0;
    end else begin : g_srcn
      assign src_v[g]    = v_q[g-1];
      assign src_side[g] = side_q[g-1];
      assign src_rem[g]  = rem_q[g-1];
      assign src_root[g] = root_q[g-1];
    end

    assign en[g] = !v_q[g] || en[g+1];

    always_comb begin
      logic [dpcr_pkg::XW:0] rm;
      logic [dpcr_pkg::XW:0] rt;
      logic [dpcr_pkg::XW:0] bb;
      rm = {1'b0, src_rem[g]};
      rt = {1'b0, src_root[g]};
      for (int j = 0; j < 2; j++) begin
        bb = (dpcr_pkg::XW+1)'(1) << (dpcr_pkg::XW - 2 - 2 * (2 * g + j));
        if (rm >= rt + bb) begin
          rm = rm - (rt + bb);
          rt = (rt >> 1) + bb;
        end else begin
          rt = rt >> 1;
        end
      end
      rem_d[g]  = rm[dpcr_pkg::XW-1:0];
      root_d[g] = rt[dpcr_pkg::XW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en[g]) begin
        v_q[g] <= src_v[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        side_q[g] <= src_side[g];
        rem_q[g]  <= rem_d[g];
        root_q[g] <= root_d[g];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign out_side_o  = side_q[NS-1];
  assign out_dist_o  = root_q[NS-1][dpcr_pkg::DISTW-1:0];

  // leftover after the root is taken never exceeds twice the root
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] |-> (rem_q[NS-1] <= {root_q[NS-1][dpcr_pkg::XW-2:0], 1'b0}))
    else $error("sqrt remainder out of range");

endmodule

// File: src/dpcr_div.sv
// ----------------------------------------------------------------------------
// dpcr_div: pipelined dividers for the unit normal
// Rounded |delta| * 2^22 / distance for both axes, two bits per stage.
// ----------------------------------------------------------------------------
module dpcr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dpcr_pkg::side_t             in_side_i,
  input  logic [dpcr_pkg::DISTW-1:0]  in_dist_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dpcr_pkg::side_t             out_side_o,
  output logic [dpcr_pkg::DISTW-1:0]  out_dist_o,
  output logic [dpcr_pkg::QW-1:0]     out_qx_o,
  output logic [dpcr_pkg::QW-1:0]     out_qy_o
);

  localparam int NS = dpcr_pkg::QW / 2 + 1;

  logic                         v_q    [NS];
  dpcr_pkg::side_t              side_q [NS];
  logic [dpcr_pkg::DISTW-1:0]   dist_q [NS];
  logic [dpcr_pkg::RMW-1:0]     rx_q [NS], ry_q [NS], rx_d [NS], ry_d [NS];
  logic [dpcr_pkg::QW-1:0]      qx_q [NS], qy_q [NS], qx_d [NS], qy_d [NS];
  logic                         en [NS+1];

  assign en[NS] = out_ready_i;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    assign en[g] = !v_q[g] || en[g+1];

    if (g == 0) begin : g_num
      // numerators with the rounding half of the divisor folded in
      always_comb begin
        rx_d[g] = dpcr_pkg::RMW'({in_side_i.mag_x, {(dpcr_pkg::NFB+dpcr_pkg::DXF){1'b0}}})
                + dpcr_pkg::RMW'(in_dist_i >> 1);
        ry_d[g] = dpcr_pkg::RMW'({in_side_i.mag_y, {(dpcr_pkg::NFB+dpcr_pkg::DXF){1'b0}}})
                + dpcr_pkg::RMW'(in_dist_i >> 1);
        qx_d[g] = '0;
        qy_d[g] = '0;
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[g] <= 1'b0;
        end else if (en[g]) begin
          v_q[g] <= in_valid_i;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en[g]) begin
          side_q[g] <= in_side_i;
          dist_q[g] <= in_dist_i;
          rx_q[g]   <= rx_d[g];
          ry_q[g]   <= ry_d[g];
          qx_q[g]   <= qx_d[g];
          qy_q[g]   <= qy_d[g];
        end
      end
    end else begin : g_iter
      always_comb begin
        logic [dpcr_pkg::RMW-1:0] rx;
        logic [dpcr_pkg::RMW-1:0] ry;
        logic [dpcr_pkg::RMW-1:0] dv;
        logic [dpcr_pkg::QW-1:0]  qx;
        logic [dpcr_pkg::QW-1:0]  qy;
        rx = rx_q[g-1];
        ry = ry_q[g-1];
        qx = qx_q[g-1];
        qy = qy_q[g-1];
        for (int j = 0; j < 2; j++) begin
          dv = dpcr_pkg::RMW'(dist_q[g-1]) << (dpcr_pkg::QW - 1 - 2 * (g - 1) - j);
          if (rx >= dv) begin
            rx = rx - dv;
            qx[dpcr_pkg::QW - 1 - 2 * (g - 1) - j] = 1'b1;
          end
          if (ry >= dv) begin
            ry = ry - dv;
            qy[dpcr_pkg::QW - 1 - 2 * (g - 1) - j] = 1'b1;
          end
        end
        rx_d[g] = rx;
        ry_d[g] = ry;
        qx_d[g] = qx;
        qy_d[g] = qy;
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[g] <= 1'b0;
        end else if (en[g]) begin
          v_q[g] <= v_q[g-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en[g]) begin
          side_q[g] <= side_q[g-1];
          dist_q[g] <= dist_q[g-1];
          rx_q[g]   <= rx_d[g];
          ry_q[g]   <= ry_d[g];
          qx_q[g]   <= qx_d[g];
          qy_q[g]   <= qy_d[g];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign out_side_o  = side_q[NS-1];
  assign out_dist_o  = dist_q[NS-1];
  assign out_qx_o    = qx_q[NS-1];
  assign out_qy_o    = qy_q[NS-1];

  // distance is at least 2^7 * |delta|, so a touching pair never tops unit length
  a_norm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-1] && side_q[NS-1].hit) |->
      (qx_q[NS-1] <= dpcr_pkg::QW'(dpcr_pkg::NORM_ONE)) &&
      (qy_q[NS-1] <= dpcr_pkg::QW'(dpcr_pkg::NORM_ONE)))
    else $error("normal component above one");

endmodule

// File: src/dpcr_back.sv
// ----------------------------------------------------------------------------
// dpcr_back: impulse, separation and saturating update
// Seven stages; the last one is the output register.
// ----------------------------------------------------------------------------
module dpcr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dpcr_pkg::side_t             in_side_i,
  input  logic [dpcr_pkg::DISTW-1:0]  in_dist_i,
  input  logic [dpcr_pkg::QW-1:0]     in_qx_i,
  input  logic [dpcr_pkg::QW-1:0]     in_qy_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dpcr_pkg::out_item_t         out_item_o
);

  localparam int NB = 7;

  function automatic logic signed [47:0] rnd(input logic signed [47:0] v, input int k);
    logic [47:0] mag;
    logic [47:0] r;
    mag = v[47] ? 48'(-v) : 48'(v);
    r   = (mag + (48'd1 << (k - 1))) >> k;
    rnd = v[47] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [dpcr_pkg::CW-1:0] sat(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = (32'sd1 <<< (dpcr_pkg::CW - 1)) - 32'sd1;
    lo = -hi - 32'sd1;
    if (v > hi)      sat = hi[dpcr_pkg::CW-1:0];
    else if (v < lo) sat = lo[dpcr_pkg::CW-1:0];
    else             sat = v[dpcr_pkg::CW-1:0];
  endfunction

  logic v_q [NB];
  logic en  [NB+1];

  dpcr_pkg::in_item_t item_q [NB-1];
  logic               hit_q  [NB-1];

  logic signed [dpcr_pkg::NW-1:0]   nx1_q, ny1_q, nx2_q, ny2_q, nx3_q, ny3_q, nx4_q, ny4_q;
  logic signed [dpcr_pkg::NW-1:0]   nx_d, ny_d;
  logic [dpcr_pkg::NW-2:0]          qcx, qcy;
  logic signed [dpcr_pkg::DVW-1:0]  dvx1_q, dvy1_q;
  logic signed [dpcr_pkg::OVW-1:0]  ov1_q;
  logic signed [dpcr_pkg::PDW-1:0]  pdx2_q, pdy2_q;
  logic signed [dpcr_pkg::POW-1:0]  pox2_q, poy2_q;
  logic signed [dpcr_pkg::DOTW-1:0] dot3_q;
  logic signed [dpcr_pkg::PXW-1:0]  px3_q, py3_q, px4_q, py4_q, px5_q, py5_q, px6_q, py6_q;
  logic signed [dpcr_pkg::IMPW-1:0] imp4_q;
  logic signed [dpcr_pkg::QVW-1:0]  qvx5_q, qvy5_q;
  logic signed [dpcr_pkg::DVRW-1:0] dvrx6_q, dvry6_q;
  logic signed [47:0]               px_w, py_w, imp_w, dvrx_w, dvry_w;
  dpcr_pkg::out_item_t              out_q, out_d;

  assign en[NB] = out_ready_i;
  for (genvar g = 0; g < NB; g++) begin : g_en
    assign en[g] = !v_q[g] || en[g+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NB; k++) v_q[k] <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NB; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // signed, clamped normal
  always_comb begin
    qcx  = (in_qx_i > dpcr_pkg::QW'(dpcr_pkg::NORM_ONE)) ?
           (dpcr_pkg::NW-1)'(dpcr_pkg::NORM_ONE) : in_qx_i[dpcr_pkg::NW-2:0];
    qcy  = (in_qy_i > dpcr_pkg::QW'(dpcr_pkg::NORM_ONE)) ?
           (dpcr_pkg::NW-1)'(dpcr_pkg::NORM_ONE) : in_qy_i[dpcr_pkg::NW-2:0];
    nx_d = in_side_i.neg_x ? -$signed({1'b0, qcx}) : $signed({1'b0, qcx});
    ny_d = in_side_i.neg_y ? -$signed({1'b0, qcy}) : $signed({1'b0, qcy});
  end

  always_comb begin
    px_w   = rnd(48'(pox2_q), dpcr_pkg::PSH);
    py_w   = rnd(48'(poy2_q), dpcr_pkg::PSH);
    imp_w  = rnd(48'(dot3_q), dpcr_pkg::NFB);
    dvrx_w = rnd(48'(qvx5_q), dpcr_pkg::NFB);
    dvry_w = rnd(48'(qvy5_q), dpcr_pkg::NFB);
  end

  always_comb begin
    if (hit_q[NB-2]) begin
      out_d.new_first_pos_x  = sat(32'($signed(item_q[NB-2].first_pos_x))  - 32'(px6_q));
      out_d.new_first_pos_y  = sat(32'($signed(item_q[NB-2].first_pos_y))  - 32'(py6_q));
      out_d.new_second_pos_x = sat(32'($signed(item_q[NB-2].second_pos_x)) + 32'(px6_q));
      out_d.new_second_pos_y = sat(32'($signed(item_q[NB-2].second_pos_y)) + 32'(py6_q));
      out_d.new_first_vel_x  = sat(32'($signed(item_q[NB-2].first_vel_x))  + 32'(dvrx6_q));
      out_d.new_first_vel_y  = sat(32'($signed(item_q[NB-2].first_vel_y))  + 32'(dvry6_q));
      out_d.new_second_vel_x = sat(32'($signed(item_q[NB-2].second_vel_x)) - 32'(dvrx6_q));
      out_d.new_second_vel_y = sat(32'($signed(item_q[NB-2].second_vel_y)) - 32'(dvry6_q));
    end else begin
      out_d.new_first_pos_x  = item_q[NB-2].first_pos_x;
      out_d.new_first_pos_y  = item_q[NB-2].first_pos_y;
      out_d.new_second_pos_x = item_q[NB-2].second_pos_x;
      out_d.new_second_pos_y = item_q[NB-2].second_pos_y;
      out_d.new_first_vel_x  = item_q[NB-2].first_vel_x;
      out_d.new_first_vel_y  = item_q[NB-2].first_vel_y;
      out_d.new_second_vel_x = item_q[NB-2].second_vel_x;
      out_d.new_second_vel_y = item_q[NB-2].second_vel_y;
    end
    out_d.hit = hit_q[NB-2];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      item_q[0] <= in_side_i.item;
      hit_q[0]  <= in_side_i.hit;
      nx1_q     <= nx_d;
      ny1_q     <= ny_d;
      dvx1_q    <= $signed({in_side_i.item.second_vel_x[dpcr_pkg::CW-1],
                            in_side_i.item.second_vel_x})
                 - $signed({in_side_i.item.first_vel_x[dpcr_pkg::CW-1],
                            in_side_i.item.first_vel_x});
      dvy1_q    <= $signed({in_side_i.item.second_vel_y[dpcr_pkg::CW-1],
                            in_side_i.item.second_vel_y})
                 - $signed({in_side_i.item.first_vel_y[dpcr_pkg::CW-1],
                            in_side_i.item.first_vel_y});
      ov1_q     <= $signed({1'b0, in_side_i.rsum, {dpcr_pkg::DXF{1'b0}}})
                 - $signed({1'b0, in_dist_i});
    end
    if (en[1]) begin
      item_q[1] <= item_q[0];
      hit_q[1]  <= hit_q[0];
      nx2_q     <= nx1_q;
      ny2_q     <= ny1_q;
      pdx2_q    <= dvx1_q * nx1_q;
      pdy2_q    <= dvy1_q * ny1_q;
      pox2_q    <= ov1_q * nx1_q;
      poy2_q    <= ov1_q * ny1_q;
    end
    if (en[2]) begin
      item_q[2] <= item_q[1];
      hit_q[2]  <= hit_q[1];
      nx3_q     <= nx2_q;
      ny3_q     <= ny2_q;
      dot3_q    <= dpcr_pkg::DOTW'(pdx2_q) + dpcr_pkg::DOTW'(pdy2_q);
      px3_q     <= px_w[dpcr_pkg::PXW-1:0];
      py3_q     <= py_w[dpcr_pkg::PXW-1:0];
    end
    if (en[3]) begin
      item_q[3] <= item_q[2];
      hit_q[3]  <= hit_q[2];
      nx4_q     <= nx3_q;
      ny4_q     <= ny3_q;
      imp4_q    <= imp_w[dpcr_pkg::IMPW-1:0];
      px4_q     <= px3_q;
      py4_q     <= py3_q;
    end
    if (en[4]) begin
      item_q[4] <= item_q[3];
      hit_q[4]  <= hit_q[3];
      qvx5_q    <= imp4_q * nx4_q;
      qvy5_q    <= imp4_q * ny4_q;
      px5_q     <= px4_q;
      py5_q     <= py4_q;
    end
    if (en[5]) begin
      item_q[5] <= item_q[4];
      hit_q[5]  <= hit_q[4];
      dvrx6_q   <= dvrx_w[dpcr_pkg::DVRW-1:0];
      dvry6_q   <= dvry_w[dpcr_pkg::DVRW-1:0];
      px6_q     <= px5_q;
      py6_q     <= py5_q;
    end
    if (en[6]) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NB-1];
  assign out_item_o  = out_q;

endmodule

// File: src/disc_pair_collision_resolver.sv
// ----------------------------------------------------------------------------
// disc_pair_collision_resolver: equal-mass elastic collision of two discs
// Touch test, unit normal, impulse exchange and half-overlap separation
// in fixed point, one disc pair per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | into      | in_valid_i/in_ready_o   | in_item_i  (two discs)
//  out     | out of    | out_valid_o/out_ready_i | out_item_o (updated discs, hit)
//
//  Takes one item per cycle unless the pipe is full and the output stalls;
//  each item passes 3 front, 11 square root, 10 divide and 7 update stages. The
//  latency is set by the square root and normal dividers, which resolve two
//  bits per stage. Every stage stalls only when it and all stages after it
//  hold items, so bubbles collapse under backpressure and an item can enter
//  while a finished result waits in the output register. Reset clears the
//  valid bits only.
//
module disc_pair_collision_resolver (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dpcr_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dpcr_pkg::out_item_t  out_item_o
);

  // front -> sqrt
  logic                        f_valid, f_ready;
  dpcr_pkg::side_t             f_side;
  logic [dpcr_pkg::XW-1:0]     f_x;

  // sqrt -> divide
  logic                        s_valid, s_ready;
  dpcr_pkg::side_t             s_side;
  logic [dpcr_pkg::DISTW-1:0]  s_dist;

  // divide -> update
  logic                        d_valid, d_ready;
  dpcr_pkg::side_t             d_side;
  logic [dpcr_pkg::DISTW-1:0]  d_dist;
  logic [dpcr_pkg::QW-1:0]     d_qx, d_qy;

  // Squared distance and touch test. A hit needs d2 < (r1 + r2)^2, which
  // matches dist < rsum * 2^7 exactly, so no root is needed for the test.
  dpcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_side_o  (f_side),
    .out_x_o     (f_x)
  );

  // dist = isqrt(d2 << 14) for pairs that can touch: distance with 7 extra fraction bits
  dpcr_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_side_i   (f_side),
    .in_x_i      (f_x),
    .out_valid_o (s_valid),
    .out_ready_i (s_ready),
    .out_side_o  (s_side),
    .out_dist_o  (s_dist)
  );

  // normal magnitudes, 15 fraction bits, rounded to nearest
  dpcr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_valid),
    .in_ready_o  (s_ready),
    .in_side_i   (s_side),
    .in_dist_i   (s_dist),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .out_side_o  (d_side),
    .out_dist_o  (d_dist),
    .out_qx_o    (d_qx),
    .out_qy_o    (d_qy)
  );

  // impulse along the normal, half-overlap push, saturation; misses pass
  dpcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .in_side_i   (d_side),
    .in_dist_i   (d_dist),
    .in_qx_i     (d_qx),
    .in_qy_i     (d_qy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // input can only back up once the whole pipe is full, output included
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipeline");

endmodule

// File: test/disc_pair_collision_resolver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// disc_pair_collision_resolver_tb: self-checking bench for the disc resolver
// Directed and random disc pairs are driven in with random idle bursts on the
// input side and random output stalls. A predictor computes each expected
// result from the item, and the monitor compares results in order.
// ----------------------------------------------------------------------------
module disc_pair_collision_resolver_tb;

  localparam int  NUM_RANDOM  = 1430;
  localparam int  LATENCY     = 31;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  QUIET_ITEMS = 200;   // last items go with no idling
  localparam longint CMAX = (64'sd1 <<< (dpcr_pkg::CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (dpcr_pkg::CW - 1));

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  dpcr_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  dpcr_pkg::out_item_t out_item_o;

  dpcr_pkg::in_item_t  pending_pairs[$];
  dpcr_pkg::out_item_t expected_results[$];
  int                  total_items;
  int                  sent_items;
  int                  in_gap;
  int                  out_gap;
  int                  cycle_count;
  bit                  failed;
  logic                in_ready_q;

  disc_pair_collision_resolver i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Round to nearest, halves away from zero.
  function automatic longint round_off(longint v, int k);
    longint half;
    half = 64'sd1 <<< (k - 1);
    if (v < 0) return -((-v + half) >>> k);
    return (v + half) >>> k;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // Bitwise integer square root, floor.
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Unit normal component, 15 fraction bits, clamped to one.
  function automatic longint normal_part(longint d, longint unsigned mag,
                                         longint unsigned center_len);
    longint unsigned q;
    q = ((mag << 22) + (center_len >> 1)) / center_len;
    if (q > dpcr_pkg::NORM_ONE) q = dpcr_pkg::NORM_ONE;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic dpcr_pkg::out_item_t resolve_pair(dpcr_pkg::in_item_t a);
    dpcr_pkg::out_item_t r;
    longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y, dx, dy;
    longint nx, ny, imp, dvx, dvy, ov, px, py;
    longint unsigned mx, my, d2, rs7, center_len;
    bit touch;
    p1x = a.first_pos_x;  p1y = a.first_pos_y;
    v1x = a.first_vel_x;  v1y = a.first_vel_y;
    p2x = a.second_pos_x; p2y = a.second_pos_y;
    v2x = a.second_vel_x; v2y = a.second_vel_y;
    dx = p2x - p1x;
    dy = p2y - p1y;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    d2 = mx * mx + my * my;
    rs7 = (longint'(a.first_radius) + longint'(a.second_radius)) << 7;
    center_len = floor_sqrt(d2 << 14);
    touch = (d2 != 0) && (center_len < rs7);
    if (touch) begin
      nx  = normal_part(dx, mx, center_len);
      ny  = normal_part(dy, my, center_len);
      imp = round_off((v2x - v1x) * nx + (v2y - v1y) * ny, 15);
      dvx = round_off(imp * nx, 15);
      dvy = round_off(imp * ny, 15);
      ov  = longint'(rs7 - center_len);
      px  = round_off(ov * nx, 23);
      py  = round_off(ov * ny, 23);
      p1x = clamp_coord(p1x - px);
      p1y = clamp_coord(p1y - py);
      p2x = clamp_coord(p2x + px);
      p2y = clamp_coord(p2y + py);
      v1x = clamp_coord(v1x + dvx);
      v1y = clamp_coord(v1y + dvy);
      v2x = clamp_coord(v2x - dvx);
      v2y = clamp_coord(v2y - dvy);
    end
    r.new_first_pos_x  = p1x[dpcr_pkg::CW-1:0];
    r.new_first_pos_y  = p1y[dpcr_pkg::CW-1:0];
    r.new_first_vel_x  = v1x[dpcr_pkg::CW-1:0];
    r.new_first_vel_y  = v1y[dpcr_pkg::CW-1:0];
    r.new_second_pos_x = p2x[dpcr_pkg::CW-1:0];
    r.new_second_pos_y = p2y[dpcr_pkg::CW-1:0];
    r.new_second_vel_x = v2x[dpcr_pkg::CW-1:0];
    r.new_second_vel_y = v2y[dpcr_pkg::CW-1:0];
    r.hit              = touch;
    return r;
  endfunction

  function automatic logic [dpcr_pkg::CW-1:0] any_coord();
    return dpcr_pkg::CW'($urandom());
  endfunction

  // Mostly touching pairs: second center near the first, random offsets.
  function automatic dpcr_pkg::in_item_t random_pair();
    dpcr_pkg::in_item_t a;
    int span;
    a.first_pos_x   = any_coord();
    a.first_pos_y   = any_coord();
    a.first_vel_x   = any_coord();
    a.first_vel_y   = any_coord();
    a.first_radius  = dpcr_pkg::RW'($urandom());
    a.second_radius = dpcr_pkg::RW'($urandom());
    a.second_vel_x  = any_coord();
    a.second_vel_y  = any_coord();
    case ($urandom_range(0, 9))
      0, 1: begin
        a.second_pos_x = any_coord();
        a.second_pos_y = any_coord();
      end
      2: begin
        // small radii and tiny offsets, incl. coincident centers
        a.first_radius  = dpcr_pkg::RW'($urandom_range(0, 8));
        a.second_radius = dpcr_pkg::RW'($urandom_range(0, 8));
        a.second_pos_x  = dpcr_pkg::CW'(a.first_pos_x + $signed($urandom_range(0, 8)) - 4);
        a.second_pos_y  = dpcr_pkg::CW'(a.first_pos_y + $signed($urandom_range(0, 8)) - 4);
      end
      default: begin
        span = int'(a.first_radius) + int'(a.second_radius) + 1;
        a.second_pos_x = dpcr_pkg::CW'(a.first_pos_x
                         + $signed($urandom_range(0, 2 * span)) - span);
        a.second_pos_y = dpcr_pkg::CW'(a.first_pos_y
                         + $signed($urandom_range(0, 2 * span)) - span);
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      // slow discs for readable impulses
      a.first_vel_x  = dpcr_pkg::CW'($signed($urandom_range(0, 2048)) - 1024);
      a.second_vel_x = dpcr_pkg::CW'($signed($urandom_range(0, 2048)) - 1024);
    end
    return a;
  endfunction

  function automatic dpcr_pkg::in_item_t make_pair(longint p1x, longint p1y,
      longint v1x, longint v1y, int r1, longint p2x, longint p2y, longint v2x,
      longint v2y, int r2);
    dpcr_pkg::in_item_t a;
    a.first_pos_x  = p1x[dpcr_pkg::CW-1:0]; a.first_pos_y  = p1y[dpcr_pkg::CW-1:0];
    a.first_vel_x  = v1x[dpcr_pkg::CW-1:0]; a.first_vel_y  = v1y[dpcr_pkg::CW-1:0];
    a.first_radius = r1[dpcr_pkg::RW-1:0];
    a.second_pos_x = p2x[dpcr_pkg::CW-1:0]; a.second_pos_y = p2y[dpcr_pkg::CW-1:0];
    a.second_vel_x = v2x[dpcr_pkg::CW-1:0]; a.second_vel_y = v2y[dpcr_pkg::CW-1:0];
    a.second_radius = r2[dpcr_pkg::RW-1:0];
    return a;
  endfunction

  // Append one item to the stimulus queue.
  task automatic add_pair(input dpcr_pkg::in_item_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  initial begin
    // directed pairs
    // coincident centers: no hit
    add_pair(make_pair(100, 100, 5, 5, 500, 100, 100, -5, 7, 500));
    // just touching on x, exactly at radius sum: no hit
    add_pair(make_pair(0, 0, 0, 0, 256, 512, 0, 0, 0, 256));
    // one below radius sum: hit
    add_pair(make_pair(0, 0, 256, 0, 256, 511, 0, -256, 0, 256));
    // diagonal head-on
    add_pair(make_pair(0, 0, 300, 300, 1000, 300, 300, -300, -300, 1000));
    // zero radii, adjacent centers: no hit
    add_pair(make_pair(0, 0, 1, 1, 0, 1, 0, 2, 2, 0));
    // max radii, adjacent centers
    add_pair(make_pair(0, 0, 0, 0, 16383, 1, 1, 0, 0, 16383));
    // extreme positions: saturation on separation
    add_pair(make_pair(CMAX, CMAX, 0, 0, 16383, CMAX - 10, CMAX, 0, 0, 16383));
    add_pair(make_pair(CMIN, CMIN, 0, 0, 16383, CMIN + 3, CMIN + 4, 0, 0, 16383));
    // extreme velocities: saturation on impulse
    add_pair(make_pair(0, 0, CMIN, CMIN, 16383, 100, 0, CMAX, CMAX, 16383));
    add_pair(make_pair(0, 0, CMAX, CMAX, 16383, 0, -100, CMIN, CMIN, 16383));
    // field extremes far apart: no hit
    add_pair(make_pair(CMIN, CMAX, CMAX, CMIN, 16383, CMAX, CMIN, CMIN, CMAX, 16383));
    // pure vertical and negative deltas
    add_pair(make_pair(0, 0, 7, -9, 200, 0, -150, -3, 11, 200));
    add_pair(make_pair(0, 0, -40, 0, 200, -150, 0, 40, 0, 200));
    // separating velocities still get an impulse
    add_pair(make_pair(0, 0, -500, 0, 300, 200, 0, 500, 0, 300));
    for (int i = 0; i < NUM_RANDOM; i++) add_pair(random_pair());
    total_items = pending_pairs.size();
  end

  // Driver: new item on the falling edge, idle bursts between items.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      in_gap     <= 0;
    end else if (!in_valid_i || in_ready_q) begin
      // previous item (if any) was taken at the last rising edge
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (pending_pairs.size() > 0) begin
        in_valid_i <= 1'b1;
        in_item_i  <= pending_pairs.pop_front();
        if (pending_pairs.size() > QUIET_ITEMS && $urandom_range(0, 5) == 0)
          in_gap <= $urandom_range(1, 15);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Accept flag captured at the rising edge so the driver reads it safely.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ready_q <= 1'b0;
    end else begin
      in_ready_q <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        expected_results.insert(expected_results.size(), resolve_pair(in_item_i));
        sent_items <= sent_items + 1;
      end
    end
  end

  // Output stall bursts.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
    end else if (out_gap > 0) begin
      out_ready_i <= 1'b0;
      out_gap     <= out_gap - 1;
    end else if (pending_pairs.size() > QUIET_ITEMS && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      out_gap     <= $urandom_range(0, 14);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    dpcr_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $realtime, out_item_o);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (out_item_o !== want) begin
          $display("%0t: mismatch, expected %p", $realtime, want);
          $display("%0t:           actual   %p", $realtime, out_item_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    failed      = 1'b0;
    sent_items  = 0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (total_items > 0 && sent_items == total_items);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $realtime);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
